FILE: rtl/gnssdf_pkg.sv
package gnssdf_pkg;

   // Special byte values
   localparam logic [7:0] SYM_DOLLAR  = 8'h24;
   localparam logic [7:0] SYM_NEWLINE = 8'h0A;
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;

   // Request command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Frame kind codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_NMEA = 2'd1;
   localparam logic [1:0] KIND_UBX  = 2'd2;

   // Link status codes
   localparam logic [1:0] ST_INIT    = 2'd0;
   localparam logic [1:0] ST_ON      = 2'd1;
   localparam logic [1:0] ST_CHIPERR = 2'd2;

   // Last header byte index (length high byte)
   localparam logic [1:0] HDR_LAST   = 2'd3;
   localparam logic [1:0] HDR_LENLOW = 2'd2;

   // Parser phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_NMEA = 5'b00010,
      PH_SYNC = 5'b00100,
      PH_HEAD = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

   // Chip presence events from the parser to the link tracker
   typedef struct packed {
      logic nmea_done;
      logic header_done;
   } event_type;

   // Frame part of one result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [1:0] frame_kind;
      logic       frame_first;
      logic       frame_end;
   } frame_type;

   // Link part of one result
   typedef struct packed {
      logic [1:0] link_status;
      logic       configure_request;
   } link_type;

endpackage

FILE: rtl/gnssdf_parser.sv
module gnssdf_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             data_byte,
   output gnssdf_pkg::frame_type  frame,
   output gnssdf_pkg::event_type  events
);

   gnssdf_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [16:0] left_ff, left_in;
   logic [16:0] left_dec;
   logic        as_idle;

   // A bad second sync byte is handled again as if idle
   always_comb begin
      left_dec = (left_ff == 17'd0) ? 17'd0 : left_ff - 17'd1;
      as_idle  = (phase_ff == gnssdf_pkg::PH_IDLE) ||
                 ((phase_ff == gnssdf_pkg::PH_SYNC) && (data_byte != gnssdf_pkg::SYNC_SECOND));
   end

   // Byte decision
   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      len_low_in = len_low_ff;
      left_in    = left_ff;
      frame      = '0;
      events     = '0;
      if (as_idle) begin
         phase_in = gnssdf_pkg::PH_IDLE;
         if (data_byte == gnssdf_pkg::SYM_DOLLAR) begin
            phase_in          = gnssdf_pkg::PH_NMEA;
            frame.out_byte    = data_byte;
            frame.out_valid   = 1'b1;
            frame.frame_kind  = gnssdf_pkg::KIND_NMEA;
            frame.frame_first = 1'b1;
         end else if (data_byte == gnssdf_pkg::SYNC_FIRST) begin
            phase_in = gnssdf_pkg::PH_SYNC;
         end
      end else begin
         unique case (phase_ff)
            gnssdf_pkg::PH_SYNC: begin
               phase_in   = gnssdf_pkg::PH_HEAD;
               hdr_idx_in = 2'd0;
            end
            gnssdf_pkg::PH_NMEA: begin
               frame.frame_kind = gnssdf_pkg::KIND_NMEA;
               if (data_byte == gnssdf_pkg::SYM_NEWLINE) begin
                  frame.frame_end  = 1'b1;
                  phase_in         = gnssdf_pkg::PH_IDLE;
                  events.nmea_done = 1'b1;
               end else begin
                  frame.out_byte  = data_byte;
                  frame.out_valid = 1'b1;
               end
            end
            gnssdf_pkg::PH_HEAD: begin
               frame.out_byte    = data_byte;
               frame.out_valid   = 1'b1;
               frame.frame_kind  = gnssdf_pkg::KIND_UBX;
               frame.frame_first = (hdr_idx_ff == 2'd0);
               if (hdr_idx_ff == gnssdf_pkg::HDR_LENLOW) begin
                  len_low_in = data_byte;
               end
               if (hdr_idx_ff == gnssdf_pkg::HDR_LAST) begin
                  // payload plus two check bytes
                  left_in            = {1'b0, data_byte, len_low_ff} + 17'd2;
                  phase_in           = gnssdf_pkg::PH_BODY;
                  hdr_idx_in         = 2'd0;
                  events.header_done = 1'b1;
               end else begin
                  hdr_idx_in = hdr_idx_ff + 2'd1;
               end
            end
            gnssdf_pkg::PH_BODY: begin
               frame.out_byte   = data_byte;
               frame.out_valid  = 1'b1;
               frame.frame_kind = gnssdf_pkg::KIND_UBX;
               left_in          = left_dec;
               if (left_dec == 17'd0) begin
                  frame.frame_end = 1'b1;
                  phase_in        = gnssdf_pkg::PH_IDLE;
               end
            end
            default: begin
               // unreachable codes: recover to idle, drop the byte
               phase_in = gnssdf_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= gnssdf_pkg::PH_IDLE;
         hdr_idx_ff <= 2'd0;
         len_low_ff <= 8'd0;
         left_ff    <= 17'd0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         len_low_ff <= len_low_in;
         left_ff    <= left_in;
      end
   end

endmodule

FILE: rtl/gnssdf_link.sv
module gnssdf_link (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr,
   input  logic [15:0]           csr_data,
   input  logic                  tick_en,
   input  logic                  byte_en,
   input  gnssdf_pkg::event_type events,
   output gnssdf_pkg::link_type  link
);

   logic [15:0] timeout_ff;
   logic [15:0] ticks_ff, ticks_in;
   logic        done_ff, done_in;
   logic        seen_ff, seen_in;
   logic [1:0]  status_ff, status_in;

   // Tick counting, timeout and presence events
   always_comb begin
      ticks_in  = ticks_ff;
      done_in   = done_ff;
      seen_in   = seen_ff;
      status_in = status_ff;
      link      = '0;
      if (tick_en) begin
         if (ticks_ff != gnssdf_pkg::TICK_MAX) begin
            ticks_in = ticks_ff + 16'd1;
         end
         if (!done_ff && (ticks_in >= timeout_ff)) begin
            done_in = 1'b1;
            seen_in = 1'b1;
            if (!seen_ff) begin
               status_in = gnssdf_pkg::ST_CHIPERR;
            end
         end
      end else if (byte_en) begin
         if (events.nmea_done || events.header_done) begin
            seen_in = 1'b1;
         end
         if (events.nmea_done) begin
            status_in              = gnssdf_pkg::ST_ON;
            link.configure_request = (status_ff != gnssdf_pkg::ST_ON);
         end
      end
      link.link_status = status_in;
   end

   // Timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= gnssdf_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         timeout_ff <= csr_data;
      end
   end

   // Link state
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= 16'd0;
         done_ff   <= 1'b0;
         seen_ff   <= 1'b0;
         status_ff <= gnssdf_pkg::ST_INIT;
      end else if (tick_en || byte_en) begin
         ticks_ff  <= ticks_in;
         done_ff   <= done_in;
         seen_ff   <= seen_in;
         status_ff <= status_in;
      end
   end

endmodule

FILE: rtl/gnss_nmea_ubx_deframer.sv
// Channel  Direction  Payload
// req_     in         tuser: command; tdata: data_byte
// rsp_     out        tuser: out_valid, frame_kind; tdata: out_byte, frame_first,
//                     link_status, configure_request; tlast: frame_end
// csr_     in         csr_data: timeout_ticks
//
// One request per cycle sustained while results are taken; a request enters the input
// register at the accepting edge and moves to the result register once that is free.
// The byte decision and tick/status update sit between those two registers.
// Synchronous active-high reset clears parser phase, counters and link status;
// timeout_ticks returns to 5000. No request or register write is taken in reset.
// A stalled result holds; one more request is still taken into the input register.
module gnss_nmea_ubx_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] frame_first,
                                    // [10:9] link_status, [11] configure_request
   output logic [2:0]  rsp_tuser,   // [0] out_valid, [2:1] frame_kind
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // timeout_ticks
);

   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   gnssdf_pkg::frame_type out_frame_ff;
   gnssdf_pkg::link_type  out_link_ff;
   logic                  out_free;
   logic                  step;
   logic                  tick_en;
   logic                  byte_en;
   gnssdf_pkg::frame_type frame;
   gnssdf_pkg::link_type  link;
   gnssdf_pkg::event_type events;

   // Handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !reset && (!in_valid_ff || out_free);
   assign csr_ready  = !reset;
   assign tick_en    = step && (in_cmd_ff == gnssdf_pkg::CMD_TICK);
   assign byte_en    = step && (in_cmd_ff == gnssdf_pkg::CMD_BYTE);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   gnssdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (byte_en),
      .data_byte (in_byte_ff),
      .frame     (frame),
      .events    (events)
   );

   gnssdf_link u_link (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .tick_en  (tick_en),
      .byte_en  (byte_en),
      .events   (events),
      .link     (link)
   );

   // Result register; ticks carry no frame content
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_frame_ff <= byte_en ? frame : '0;
         out_link_ff  <= link;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_link_ff.configure_request, out_link_ff.link_status,
                        out_frame_ff.frame_first, out_frame_ff.out_byte};
   assign rsp_tuser  = {out_frame_ff.frame_kind, out_frame_ff.out_valid};
   assign rsp_tlast  = out_frame_ff.frame_end;

   // Checks
   a_cfg_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_link_ff.configure_request) |->
         (out_link_ff.link_status == gnssdf_pkg::ST_ON))
      else $error("configure request without status on");

   a_first_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_frame_ff.frame_first) |-> out_frame_ff.out_valid)
      else $error("frame start without content byte");

   a_nmea_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_frame_ff.frame_end &&
       (out_frame_ff.frame_kind == gnssdf_pkg::KIND_NMEA)) |->
         (!out_frame_ff.out_valid && out_link_ff.link_status == gnssdf_pkg::ST_ON))
      else $error("line end carries content or leaves status off");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both registers are full");

endmodule

FILE: sim/testbench.sv
module testbench;

   // One predicted result: frame part and link part
   typedef struct packed {
      gnssdf_pkg::frame_type frame;
      gnssdf_pkg::link_type  link;
   } deframe_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = gnssdf_pkg::CMD_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'd0;

   // Deframer shadow state
   gnssdf_pkg::phase_type phase_m;
   logic [1:0]  hdr_m;
   logic [7:0]  len_low_m;
   logic [16:0] bytes_left_m;
   logic        chip_seen_m;
   logic [1:0]  status_m;
   logic [15:0] tick_count_m;
   logic        timeout_done_m;
   logic [15:0] timeout_ticks_m;

   deframe_result_type pending_results[$];
   int mismatch_count = 0;
   int result_count   = 0;
   int requests_sent  = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int stall_left = 0;

   gnss_nmea_ubx_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Shadow state after reset
   task automatic reset_shadow();
      phase_m         = gnssdf_pkg::PH_IDLE;
      hdr_m           = 2'd0;
      len_low_m       = 8'd0;
      bytes_left_m    = 17'd0;
      chip_seen_m     = 1'b0;
      status_m        = gnssdf_pkg::ST_INIT;
      tick_count_m    = 16'd0;
      timeout_done_m  = 1'b0;
      timeout_ticks_m = gnssdf_pkg::TIMEOUT_RESET;
   endtask

   // Expected result of one request; advances the shadow state
   function automatic deframe_result_type predict_deframe(logic cmd, logic [7:0] b);
      deframe_result_type    r;
      gnssdf_pkg::phase_type ph;
      logic                  consumed;
      r        = '0;
      consumed = 1'b0;
      if (cmd == gnssdf_pkg::CMD_TICK) begin
         if (tick_count_m < gnssdf_pkg::TICK_MAX)
            tick_count_m = tick_count_m + 16'd1;
         // timeout fires once only
         if (!timeout_done_m && tick_count_m >= timeout_ticks_m) begin
            timeout_done_m = 1'b1;
            if (!chip_seen_m)
               status_m = gnssdf_pkg::ST_CHIPERR;
            chip_seen_m = 1'b1;
         end
      end else begin
         ph = phase_m;
         // second sync byte: take it, or drop the B5 and look at this byte afresh
         if (ph == gnssdf_pkg::PH_SYNC) begin
            if (b == gnssdf_pkg::SYNC_SECOND) begin
               phase_m  = gnssdf_pkg::PH_HEAD;
               hdr_m    = 2'd0;
               consumed = 1'b1;
            end else begin
               ph = gnssdf_pkg::PH_IDLE;
            end
         end
         if (!consumed) begin
            case (ph)
               gnssdf_pkg::PH_NMEA: begin
                  r.frame.frame_kind = gnssdf_pkg::KIND_NMEA;
                  if (b == gnssdf_pkg::SYM_NEWLINE) begin
                     r.frame.frame_end = 1'b1;
                     phase_m     = gnssdf_pkg::PH_IDLE;
                     chip_seen_m = 1'b1;
                     if (status_m != gnssdf_pkg::ST_ON)
                        r.link.configure_request = 1'b1;
                     status_m = gnssdf_pkg::ST_ON;
                  end else begin
                     r.frame.out_byte  = b;
                     r.frame.out_valid = 1'b1;
                  end
               end
               gnssdf_pkg::PH_HEAD: begin
                  r.frame.out_byte   = b;
                  r.frame.out_valid  = 1'b1;
                  r.frame.frame_kind = gnssdf_pkg::KIND_UBX;
                  if (hdr_m == 2'd0)
                     r.frame.frame_first = 1'b1;
                  if (hdr_m == gnssdf_pkg::HDR_LENLOW)
                     len_low_m = b;
                  if (hdr_m == gnssdf_pkg::HDR_LAST) begin
                     bytes_left_m = {1'b0, b, len_low_m} + 17'd2;
                     phase_m      = gnssdf_pkg::PH_BODY;
                     hdr_m        = 2'd0;
                     chip_seen_m  = 1'b1;
                  end else begin
                     hdr_m = hdr_m + 2'd1;
                  end
               end
               gnssdf_pkg::PH_BODY: begin
                  r.frame.out_byte   = b;
                  r.frame.out_valid  = 1'b1;
                  r.frame.frame_kind = gnssdf_pkg::KIND_UBX;
                  if (bytes_left_m != 17'd0)
                     bytes_left_m = bytes_left_m - 17'd1;
                  if (bytes_left_m == 17'd0) begin
                     r.frame.frame_end = 1'b1;
                     phase_m = gnssdf_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_m = gnssdf_pkg::PH_IDLE;
                  if (b == gnssdf_pkg::SYM_DOLLAR) begin
                     phase_m = gnssdf_pkg::PH_NMEA;
                     r.frame.out_byte    = b;
                     r.frame.out_valid   = 1'b1;
                     r.frame.frame_kind  = gnssdf_pkg::KIND_NMEA;
                     r.frame.frame_first = 1'b1;
                  end else if (b == gnssdf_pkg::SYNC_FIRST) begin
                     phase_m = gnssdf_pkg::PH_SYNC;
                  end
               end
            endcase
         end
      end
      r.link.link_status = status_m;
      return r;
   endfunction

   // One line per mismatch, each one counted
   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at result %0d: %s", result_count, what);
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Result checker
   always @(posedge clock) begin : check_results
      deframe_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            compare_field("out_byte", rsp_tdata[7:0], want.frame.out_byte);
            compare_field("out_valid", 8'(rsp_tuser[0]), 8'(want.frame.out_valid));
            compare_field("frame_kind", 8'(rsp_tuser[2:1]), 8'(want.frame.frame_kind));
            compare_field("frame_first", 8'(rsp_tdata[8]), 8'(want.frame.frame_first));
            compare_field("frame_end", 8'(rsp_tlast), 8'(want.frame.frame_end));
            compare_field("link_status", 8'(rsp_tdata[10:9]),
                          8'(want.link.link_status));
            compare_field("configure_request", 8'(rsp_tdata[11]),
                          8'(want.link.configure_request));
         end
         result_count++;
      end
   end

   // Result receiver: random stalls, plus long hold-offs on demand
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // Offer one request and wait for it to be taken; starts and ends at a falling edge
   task automatic send_request(logic cmd, logic [7:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_deframe(cmd, b));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_request(gnssdf_pkg::CMD_BYTE, b);
   endtask

   task automatic send_tick();
      send_request(gnssdf_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering and wait until every expected result has come
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      timeout_ticks_m = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_nmea_line(int n);
      logic [7:0] b;
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == gnssdf_pkg::SYM_NEWLINE);
         send_byte(b);
      end
      send_byte(gnssdf_pkg::SYM_NEWLINE);
   endtask

   task automatic send_ubx_frame(logic [15:0] len);
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(gnssdf_pkg::SYNC_SECOND);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      // payload and two check bytes
      repeat (int'(len) + 2)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   // Ticks before the chip is seen, then a register value below the count
   task automatic test_timeout_flag();
      send_tick();
      send_tick();
      send_byte(8'h00);
      send_byte(8'hFF);
      write_timeout(16'd1);
      send_tick();
   endtask

   // Lines after a chip error; embedded specials; second line while on
   task automatic test_nmea_lines();
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      send_byte(8'h41);
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      send_byte(gnssdf_pkg::SYM_NEWLINE);
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      send_byte(gnssdf_pkg::SYM_NEWLINE);
   endtask

   // Bad sync pairs and a zero-length frame holding newline and dollar
   task automatic test_ubx_frames();
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      send_byte(gnssdf_pkg::SYM_NEWLINE);
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(gnssdf_pkg::SYNC_SECOND);
      send_byte(gnssdf_pkg::SYM_NEWLINE);
      send_byte(gnssdf_pkg::SYM_DOLLAR);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(gnssdf_pkg::SYNC_FIRST);
      send_byte(8'hFF);
   endtask

   // Long output hold-off while requests keep coming
   task automatic test_output_stall();
      int saved_idle;
      saved_idle      = sender_idle_pct;
      sender_idle_pct = 0;
      stall_left      = 200;
      send_nmea_line(40);
      sender_idle_pct = saved_idle;
   endtask

   // Length low byte with its top bit set, read as unsigned
   task automatic test_ubx_high_low_byte();
      send_ubx_frame(16'h00FF);
   endtask

   // Mostly whole frames with random content, some noise, ticks and broken syncs
   task automatic test_random_traffic(int n);
      int target;
      int pick;
      logic [7:0] b;
      target = requests_sent + n;
      while (requests_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_nmea_line($urandom_range(0, 12));
         end else if (pick < 75) begin
            if ($urandom_range(0, 19) == 0)
               send_ubx_frame(16'($urandom_range(256, 300)));
            else
               send_ubx_frame(16'($urandom_range(0, 12)));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 3))
               send_tick();
         end else begin
            send_byte(gnssdf_pkg::SYNC_FIRST);
            do b = 8'($urandom_range(0, 255)); while (b == gnssdf_pkg::SYNC_SECOND);
            send_byte(b);
         end
      end
   endtask

   // Main sequence
   initial begin
      reset_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct   = 25;
      receiver_idle_pct = 60;
      test_timeout_flag();
      test_nmea_lines();
      test_ubx_frames();
      test_output_stall();
      test_random_traffic(400);

      write_timeout(16'hFFFF);
      sender_idle_pct   = 60;
      receiver_idle_pct = 25;
      test_random_traffic(400);

      write_timeout(16'($urandom_range(1, 65535)));
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_ubx_high_low_byte();
      test_random_traffic(400);

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/gnssdf_pkg.sv
rtl/gnssdf_parser.sv
rtl/gnssdf_link.sv
rtl/gnss_nmea_ubx_deframer.sv
sim/testbench.sv
